### hw/rtl/rtte_pkg.sv
// Shared types and constants for the round-trip timeout estimator.
// No dependencies; imported by every rtte module.
package rtte_pkg;

  localparam int NumClassesDef     = 5;
  localparam int TicksPerSecondDef = 1000;
  localparam int MaxClasses        = 16;
  localparam int BaseTimeoutReset  = 200;

  localparam int OpW      = 2;
  localparam int ClassW   = 3;
  localparam int SampleW  = 32;
  localparam int TimeoutW = 24;
  localparam int StateW   = 32;
  localparam int SlotMaxW = $clog2(MaxClasses);

  typedef enum logic [OpW-1:0] {
    OP_RESTART = 2'd0,
    OP_UPDATE  = 2'd1,
    OP_QUERY   = 2'd2
  } op_e;

  // Command from the execute stage to the slot table
  typedef struct packed {
    logic                restart;
    logic                update;
    logic [SlotMaxW-1:0] slot;
    logic [SampleW-1:0]  sample;
  } slot_cmd_t;

endpackage

### hw/rtl/rtte_slot_table.sv
// Per-class smoothed RTT and deviation registers with restart and update logic.
// Depends on rtte_pkg.
module rtte_slot_table import rtte_pkg::*; #(
  parameter int NumClasses     = NumClassesDef,
  parameter int TicksPerSecond = TicksPerSecondDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  slot_cmd_t           cmd_i,
  input  logic [TimeoutW-1:0] base_i,
  output logic [StateW-1:0]   rd_srtt_o,
  output logic [StateW-1:0]   rd_sdev_o
);

  localparam int SlotW = (NumClasses > 1) ? $clog2(NumClasses) : 1;
  localparam logic [StateW-1:0] RtoInit = StateW'(TicksPerSecond / 5);
  localparam logic [StateW-1:0] RtoMin  = StateW'(TicksPerSecond / 10);
  localparam logic [StateW-1:0] BaseRst = StateW'(BaseTimeoutReset);
  localparam logic [StateW-1:0] ResetSeed =
    (BaseRst > RtoInit) ? ((BaseRst - RtoInit) << 3) : '0;

  logic [StateW-1:0] srtt_q [NumClasses];
  logic [StateW-1:0] sdev_q [NumClasses];

  logic [SlotW-1:0]  slot;
  logic [StateW-1:0] base_ext;
  logic [StateW-1:0] seed;
  logic [StateW-1:0] sample;
  logic [StateW-1:0] srtt_shr;
  logic [StateW-1:0] sdev_shr;
  logic [StateW-1:0] err;
  logic [StateW-1:0] err_abs;
  logic [StateW-1:0] srtt_d;
  logic [StateW-1:0] sdev_sum;
  logic [StateW-1:0] sdev_d;

  assign slot      = cmd_i.slot[SlotW-1:0];
  assign rd_srtt_o = srtt_q[slot];
  assign rd_sdev_o = sdev_q[slot];

  always_comb begin
    base_ext = {{(StateW-TimeoutW){1'b0}}, base_i};
    seed     = (base_ext > RtoInit) ? ((base_ext - RtoInit) << 3) : '0;
  end

  // Update arithmetic: both shifts arithmetic, everything wraps at 32 bits
  always_comb begin
    sample   = (cmd_i.sample == '0) ? StateW'(1) : cmd_i.sample;
    srtt_shr = {{3{rd_srtt_o[StateW-1]}}, rd_srtt_o[StateW-1:3]};
    sdev_shr = {{2{rd_sdev_o[StateW-1]}}, rd_sdev_o[StateW-1:2]};
    err      = sample - srtt_shr;
    srtt_d   = rd_srtt_o + err;
    err_abs  = err[StateW-1] ? (~err + StateW'(1)) : err;
    sdev_sum = (rd_sdev_o - sdev_shr) + err_abs;
    sdev_d   = (sdev_sum[StateW-1] || (sdev_sum < RtoMin)) ? RtoMin : sdev_sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumClasses; i++) begin
        srtt_q[i] <= ResetSeed;
        sdev_q[i] <= RtoInit;
      end
    end else if (cmd_i.restart) begin
      for (int i = 0; i < NumClasses; i++) begin
        srtt_q[i] <= seed;
        sdev_q[i] <= RtoInit;
      end
    end else if (cmd_i.update) begin
      srtt_q[slot] <= srtt_d;
      sdev_q[slot] <= sdev_d;
    end
  end

  // Deviation never drops below the floor, from reset onwards
  a_sdev_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_sdev_o >= RtoMin && !rd_sdev_o[StateW-1])
    else $error("smoothed deviation below floor");

  a_restart_dev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.restart |=> sdev_q[0] == RtoInit)
    else $error("restart did not seed deviation");

endmodule

### hw/rtl/rtte_timeout_calc.sv
// Retransmit timeout from one slot's smoothed RTT and deviation, with cap.
// Depends on rtte_pkg.
module rtte_timeout_calc import rtte_pkg::*; #(
  parameter int TicksPerSecond = TicksPerSecondDef
) (
  input  logic [StateW-1:0]   srtt_i,
  input  logic [StateW-1:0]   sdev_i,
  input  logic                class_valid_i,
  input  logic [TimeoutW-1:0] base_i,
  output logic [TimeoutW-1:0] timeout_o
);

  localparam logic [StateW-1:0] RtoMax = StateW'(60 * TicksPerSecond);

  logic [StateW-1:0] rounded;
  logic [StateW-1:0] sum;
  logic [StateW-1:0] capped;

  always_comb begin
    rounded = (srtt_i + StateW'(7)) >> 3;
    sum     = rounded + sdev_i;
    capped  = (sum > RtoMax) ? RtoMax : sum;
    // Unestimated classes answer the configured default
    timeout_o = class_valid_i ? capped[TimeoutW-1:0] : base_i;
  end

endmodule

### hw/rtl/rtt_timeout_estimator_unit.sv
// Top level of the per-class round-trip timeout estimator.
// Depends on rtte_pkg, rtte_slot_table and rtte_timeout_calc.
//
// Usage: one command channel (operation_i, timer_class_i, sample_i with
// in_valid_i/in_ready_o) and one result channel (timeout_o with
// out_valid_o/out_ready_i). Restart and update transactions give no
// result; a query gives one timeout transaction. Each accepted transaction
// lands in an input register and executes from there against the five-entry
// slot registers; a query result is registered, so out_valid_o rises in the
// cycle after the query executes. Throughput is one transaction per cycle while
// no query is blocked, set by the single execute stage. When the receiver
// stalls, a waiting result holds; one further query may sit in the input
// register, after which in_ready_o drops. Restarts and updates keep flowing
// while no query is blocked in the input register. base_timeout is written
// through cfg_we_i/cfg_wdata_i only while idle, a user rule the block does not
// check. Reset clears both channels, sets base_timeout to 200 ticks and seeds
// all slots as a restart with that value would; no clearing pass is needed.
module rtt_timeout_estimator_unit import rtte_pkg::*; #(
  parameter int NumClasses     = NumClassesDef,
  parameter int TicksPerSecond = TicksPerSecondDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [OpW-1:0]             operation_i,
  input  logic [ClassW-1:0]          timer_class_i,
  input  logic signed [SampleW-1:0]  sample_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [TimeoutW-1:0]        timeout_o,
  input  logic                       cfg_we_i,
  input  logic [TimeoutW-1:0]        cfg_wdata_i
);

  localparam logic [TimeoutW-1:0] RtoMax = TimeoutW'(60 * TicksPerSecond);
  localparam int CmpW = SlotMaxW + 1;

  logic                 in_valid_q;
  logic [OpW-1:0]       op_q;
  logic [ClassW-1:0]    class_q;
  logic [SampleW-1:0]   sample_q;
  logic [TimeoutW-1:0]  base_q;
  logic                 out_valid_q, out_valid_d;
  logic [TimeoutW-1:0]  timeout_q;

  logic                 is_query;
  logic                 is_update;
  logic                 is_restart;
  logic                 out_free;
  logic                 advance;
  logic                 class_valid;
  logic [CmpW-1:0]      class_ext;
  logic [CmpW-1:0]      slot_ext;
  slot_cmd_t            cmd;
  logic [StateW-1:0]    rd_srtt;
  logic [StateW-1:0]    rd_sdev;
  logic [TimeoutW-1:0]  timeout_d;

  always_comb begin
    is_query   = (op_q == OP_QUERY);
    is_update  = (op_q == OP_UPDATE);
    is_restart = (op_q == OP_RESTART);
    out_free   = !out_valid_q || out_ready_i;
    advance    = in_valid_q && (!is_query || out_free);
    in_ready_o = !in_valid_q || advance;
  end

  always_comb begin
    class_ext   = {{(CmpW-ClassW){1'b0}}, class_q};
    class_valid = (class_q != '0) && (class_ext <= CmpW'(NumClasses));
    slot_ext    = class_valid ? (class_ext - CmpW'(1)) : '0;
    cmd.restart = advance && is_restart;
    // Drop updates for unestimated classes and negative samples
    cmd.update  = advance && is_update && class_valid && !sample_q[SampleW-1];
    cmd.slot    = slot_ext[SlotMaxW-1:0];
    cmd.sample  = sample_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q     <= OP_RESTART;
      class_q  <= '0;
      sample_q <= '0;
    end else if (in_ready_o && in_valid_i) begin
      op_q     <= operation_i;
      class_q  <= timer_class_i;
      sample_q <= sample_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= TimeoutW'(BaseTimeoutReset);
    end else if (cfg_we_i) begin
      base_q <= cfg_wdata_i;
    end
  end

  rtte_slot_table #(
    .NumClasses     (NumClasses),
    .TicksPerSecond (TicksPerSecond)
  ) u_slot_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .base_i    (base_q),
    .rd_srtt_o (rd_srtt),
    .rd_sdev_o (rd_sdev)
  );

  rtte_timeout_calc #(
    .TicksPerSecond (TicksPerSecond)
  ) u_timeout_calc (
    .srtt_i        (rd_srtt),
    .sdev_i        (rd_sdev),
    .class_valid_i (class_valid),
    .base_i        (base_q),
    .timeout_o     (timeout_d)
  );

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (advance && is_query) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && is_query) begin
      timeout_q <= timeout_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign timeout_o   = timeout_q;

  // Restart and update transactions never raise a result
  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !is_query) |=> (!out_valid_q || $past(out_valid_q)))
    else $error("result raised by non-query transaction");

  // A result is either capped or the configured default
  a_timeout_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (timeout_q <= RtoMax || timeout_q == base_q))
    else $error("timeout above cap");

endmodule
